@@ rtl/video_chip_register_interface_defines.svh @@
// Assertion macros shared by the register interface RTL.
`ifndef VIDEO_CHIP_REGISTER_INTERFACE_DEFINES_SVH
`define VIDEO_CHIP_REGISTER_INTERFACE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define VCRI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define VCRI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/vcri_pkg.sv @@
// Shared constants and types of the video chip register interface.
package vcri_pkg;

	// Item kinds.
	localparam logic [1:0] ACT_READ      = 2'd0;
	localparam logic [1:0] ACT_WRITE     = 2'd1;
	localparam logic [1:0] ACT_VBLANK    = 2'd2;
	localparam logic [1:0] ACT_PRERENDER = 2'd3;

	// Register numbers within the eight-register window.
	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	// Nametable mirroring codes.
	localparam logic [1:0] MIR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIR_HORIZONTAL = 2'd1;

	// Status flag positions and control and mask bits.
	localparam int STAT_VBLANK  = 2;
	localparam int CTRL_STEP32  = 2;
	localparam int CTRL_NMI_EN  = 7;
	localparam int MASK_GREY    = 0;

	// Video address map, decoded on 14 bits.
	localparam logic [13:0] NAME_BASE = 14'h2000;
	localparam logic [13:0] PAL_BASE  = 14'h3F00;

	localparam logic [7:0] PAL_MASK_GREY = 8'h30;
	localparam logic [7:0] PAL_MASK_FULL = 8'h3F;

	localparam logic [15:0] STEP_NARROW = 16'd1;
	localparam logic [15:0] STEP_WIDE   = 16'd32;

	localparam int PALETTE_ENTRIES = 32;
	localparam int PAL_IW          = 5;

	// Memory port controls from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic spr_we;
		logic name_we;
		logic pal_we;
	} mem_ctl_t;

	typedef enum logic [1:0] {
		RGN_EXT,
		RGN_NAME,
		RGN_PAL
	} region_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

@@ rtl/vcri_if.sv @@
// Handshake channels for command items and result items.
interface vcri_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [2:0] reg_select;
	logic [7:0] write_data;
	logic [7:0] ext_read_data;

	modport source (output valid, action, reg_select, write_data, ext_read_data, input ready);
	modport sink (input valid, action, reg_select, write_data, ext_read_data, output ready);
endinterface

interface vcri_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        nmi_pulse;
	logic [15:0] video_address;
	logic        ext_write;
	logic [13:0] ext_address;
	logic [7:0]  ext_write_data;
	logic        ext_read_used;

	modport source (output valid, read_data, nmi_pulse, video_address, ext_write,
		ext_address, ext_write_data, ext_read_used, input ready);
	modport sink (input valid, read_data, nmi_pulse, video_address, ext_write,
		ext_address, ext_write_data, ext_read_used, output ready);
endinterface

@@ rtl/vcri_mem.sv @@
// Sprite, nametable and palette memories with registered reads and the clearing pass.
module vcri_mem #(
	parameter int PAGE_BYTES   = 1024,
	parameter int SPRITE_BYTES = 256,
	localparam int SW = $clog2(SPRITE_BYTES),
	localparam int NW = $clog2(2 * PAGE_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vcri_pkg::mem_ctl_t ctl,
	input  logic [SW-1:0]      spr_idx,
	input  logic [NW-1:0]      name_idx,
	input  logic [4:0]         pal_idx,
	input  logic [7:0]         wdata,
	output logic [7:0]         spr_rdata,
	output logic [7:0]         name_rdata,
	output logic [7:0]         pal_rdata,
	output logic               clr_busy
);
	import vcri_pkg::*;

	localparam int NAME_DEPTH = 2 * PAGE_BYTES;

	logic [7:0] spr_mem [SPRITE_BYTES];
	logic [7:0] name_mem [NAME_DEPTH];
	logic [7:0] pal_mem [PALETTE_ENTRIES];

	logic [SPRITE_BYTES-1:0]    spr_vld_q;
	logic [PALETTE_ENTRIES-1:0] pal_vld_q;

	logic [7:0] spr_rd_s1;
	logic [7:0] name_rd_s1;
	logic [7:0] pal_rd_s1;
	logic       spr_ok_s1;
	logic       pal_ok_s1;

	logic          clr_busy_q;
	logic [NW-1:0] clr_idx_q;

	// Sprite memory; entries never written since reset read as zero.
	always_ff @(posedge clk) begin
		if (ctl.spr_we) begin
			spr_mem[spr_idx] <= wdata;
		end
		if (ctl.rd_en) begin
			spr_rd_s1 <= spr_mem[spr_idx];
			spr_ok_s1 <= spr_vld_q[spr_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_vld_q <= '0;
		end else if (ctl.spr_we) begin
			spr_vld_q[spr_idx] <= 1'b1;
		end
	end

	// Palette memory, same scheme.
	always_ff @(posedge clk) begin
		if (ctl.pal_we) begin
			pal_mem[pal_idx] <= wdata;
		end
		if (ctl.rd_en) begin
			pal_rd_s1 <= pal_mem[pal_idx];
			pal_ok_s1 <= pal_vld_q[pal_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (ctl.pal_we) begin
			pal_vld_q[pal_idx] <= 1'b1;
		end
	end

	// Nametable memory; zeroed one entry per cycle after reset.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			name_mem[clr_idx_q] <= '0;
		end else if (ctl.name_we) begin
			name_mem[name_idx] <= wdata;
		end
		if (ctl.rd_en) begin
			name_rd_s1 <= name_mem[name_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == NW'(NAME_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + NW'(1);
		end
	end

	assign spr_rdata  = spr_ok_s1 ? spr_rd_s1 : '0;
	assign pal_rdata  = pal_ok_s1 ? pal_rd_s1 : '0;
	assign name_rdata = name_rd_s1;
	assign clr_busy   = clr_busy_q;

endmodule

@@ rtl/video_chip_register_interface.sv @@
// Top level of the video chip register interface: sequencer, register state and result register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------------------
//   cmd      | in  | valid / ready      | action, reg_select, write_data, ext_read_data
//   rsp      | out | valid / ready      | read_data, nmi_pulse, video_address, ext_*
//   cfg      | in  | cfg_we, no stall   | cfg_wdata (nametable mirroring mode)
//
// In the cycle an item is accepted the synchronous sprite, nametable and palette memories
// are read at the addresses given by the current state; in the execute state that follows,
// the sequencer merges the read data, writes back and loads the result register.
// One item is in flight at a time: a new item is accepted only after the last completes.
// After reset the nametable memory is zeroed over its 2 * PAGE_BYTES entries (2048 at the
// default size); no item is accepted during that pass, but configuration writes are.
// If a result is still waiting when the next one is done, that item waits in the execute
// state, changing no register or memory, until the result register frees up.
`include "video_chip_register_interface_defines.svh"

module video_chip_register_interface #(
	parameter int PAGE_BYTES   = 1024,
	parameter int SPRITE_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	vcri_cmd_if.sink   cmd,
	vcri_rsp_if.source rsp
);
	import vcri_pkg::*;

	localparam int SW = $clog2(SPRITE_BYTES);
	localparam int NW = $clog2(2 * PAGE_BYTES);

	// Sequencer and configuration.
	state_t     state_q;
	logic [1:0] mirror_q;

	// Architectural register state.
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic [2:0]  status_q;
	logic        toggle_q;
	logic [15:0] temp_q;
	logic [15:0] cur_q;
	logic [7:0]  rbuf_q;
	logic [7:0]  sprptr_q;

	// The accepted item, held for the execute state.
	logic [1:0] act_s1;
	logic [2:0] sel_s1;
	logic [7:0] wdata_s1;
	logic [7:0] xdata_s1;

	// Result register.
	logic        out_vld_q;
	logic [7:0]  rd_q;
	logic        nmi_q;
	logic [15:0] vaddr_q;
	logic        ext_wr_q;
	logic [13:0] ext_addr_q;
	logic [7:0]  ext_wd_q;
	logic        ext_used_q;

	// Next values computed in the execute state.
	logic [7:0]  ctrl_d;
	logic [7:0]  mask_d;
	logic [2:0]  status_d;
	logic        toggle_d;
	logic [15:0] temp_d;
	logic [15:0] cur_d;
	logic [7:0]  rbuf_d;
	logic [7:0]  sprptr_d;
	logic [7:0]  rd_d;
	logic        nmi_d;
	logic        ext_wr_d;
	logic [13:0] ext_addr_d;
	logic [7:0]  ext_wd_d;
	logic        ext_used_d;
	logic [7:0]  fetch;

	// Address decode.
	logic [13:0]   a14;
	region_t       region;
	logic          name_ok;
	logic          page;
	logic [13:0]   off_raw;
	logic [13:0]   off_mod;
	logic [13:0]   name_sum;
	logic [NW-1:0] name_idx;
	logic [4:0]    pal_idx;
	logic [9:0]    spr_raw;
	logic [9:0]    spr_mod;
	logic [SW-1:0] spr_idx;
	logic [15:0]   cur_step;

	// Memory interface.
	mem_ctl_t   mem_ctl;
	logic [7:0] spr_rdata;
	logic [7:0] name_rdata;
	logic [7:0] pal_rdata;
	logic       clr_busy;

	logic cmd_acc;
	logic commit;
	logic is_data_write;

	assign cmd.ready = (state_q == ST_IDLE) && !clr_busy;
	assign cmd_acc   = cmd.valid && cmd.ready;
	// The execute state completes only when the result register can take the result.
	assign commit    = (state_q == ST_EXEC) && (!out_vld_q || rsp.ready);

	// The data port decodes the current video address on 14 bits. The address does not
	// change between the read in the accept cycle and the write-back when the item completes.
	assign a14 = cur_q[13:0];

	always_comb begin
		if (a14 < NAME_BASE) begin
			region = RGN_EXT;
		end else if (a14 < PAL_BASE) begin
			region = RGN_NAME;
		end else begin
			region = RGN_PAL;
		end
	end

	// Nametable slot: the mirroring mode picks which address bit selects the page, and the
	// low ten bits are folded into the page size.
	assign name_ok = (mirror_q == MIR_VERTICAL) || (mirror_q == MIR_HORIZONTAL);
	assign page    = (mirror_q == MIR_VERTICAL) ? a14[10] : a14[11];
	assign off_raw = {4'b0000, a14[9:0]};

	always_comb begin
		if (off_raw >= 14'(3 * PAGE_BYTES)) begin
			off_mod = off_raw - 14'(3 * PAGE_BYTES);
		end else if (off_raw >= 14'(2 * PAGE_BYTES)) begin
			off_mod = off_raw - 14'(2 * PAGE_BYTES);
		end else if (off_raw >= 14'(PAGE_BYTES)) begin
			off_mod = off_raw - 14'(PAGE_BYTES);
		end else begin
			off_mod = off_raw;
		end
	end

	assign name_sum = page ? (off_mod + 14'(PAGE_BYTES)) : off_mod;
	assign name_idx = name_sum[NW-1:0];

	// Palette slot: the backdrop entries of the sprite palettes alias the background ones.
	always_comb begin
		pal_idx = a14[4:0];
		if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
			pal_idx[4] = 1'b0;
		end
	end

	// The sprite pointer wraps at 256 but indexes the sprite memory modulo its size.
	assign spr_raw = {2'b00, sprptr_q};

	always_comb begin
		if (spr_raw >= 10'(3 * SPRITE_BYTES)) begin
			spr_mod = spr_raw - 10'(3 * SPRITE_BYTES);
		end else if (spr_raw >= 10'(2 * SPRITE_BYTES)) begin
			spr_mod = spr_raw - 10'(2 * SPRITE_BYTES);
		end else if (spr_raw >= 10'(SPRITE_BYTES)) begin
			spr_mod = spr_raw - 10'(SPRITE_BYTES);
		end else begin
			spr_mod = spr_raw;
		end
	end

	assign spr_idx  = spr_mod[SW-1:0];
	assign cur_step = cur_q + (ctrl_q[CTRL_STEP32] ? STEP_WIDE : STEP_NARROW);

	// Memory reads go out with the accept; writes go out when the item completes.
	assign is_data_write   = commit && (act_s1 == ACT_WRITE) && (sel_s1 == REG_DATA);
	assign mem_ctl.rd_en   = cmd_acc;
	assign mem_ctl.spr_we  = commit && (act_s1 == ACT_WRITE) && (sel_s1 == REG_OAM_DATA);
	assign mem_ctl.name_we = is_data_write && (region == RGN_NAME) && name_ok;
	assign mem_ctl.pal_we  = is_data_write && (region == RGN_PAL);

	vcri_mem #(
		.PAGE_BYTES  (PAGE_BYTES),
		.SPRITE_BYTES(SPRITE_BYTES)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mem_ctl),
		.spr_idx   (spr_idx),
		.name_idx  (name_idx),
		.pal_idx   (pal_idx),
		.wdata     (wdata_s1),
		.spr_rdata (spr_rdata),
		.name_rdata(name_rdata),
		.pal_rdata (pal_rdata),
		.clr_busy  (clr_busy)
	);

	// Byte fetched for a data port read. Pattern space comes from the external byte that
	// arrived with the item; palette bytes are trimmed by the greyscale bit of the mask.
	always_comb begin
		case (region)
			RGN_EXT:  fetch = xdata_s1;
			RGN_NAME: fetch = name_ok ? name_rdata : '0;
			RGN_PAL:  fetch = pal_rdata & (mask_q[MASK_GREY] ? PAL_MASK_GREY : PAL_MASK_FULL);
			default:  fetch = '0;
		endcase
	end

	// Register read and write behavior.
	always_comb begin
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		status_d   = status_q;
		toggle_d   = toggle_q;
		temp_d     = temp_q;
		cur_d      = cur_q;
		rbuf_d     = rbuf_q;
		sprptr_d   = sprptr_q;
		rd_d       = '0;
		nmi_d      = 1'b0;
		ext_wr_d   = 1'b0;
		ext_addr_d = '0;
		ext_wd_d   = '0;
		ext_used_d = 1'b0;
		case (act_s1)
			ACT_READ: begin
				case (sel_s1)
					REG_STATUS: begin
						// Flags over the low bits of the read buffer; the read clears
						// the vblank flag and the shared write toggle.
						rd_d                  = {status_q, rbuf_q[4:0]};
						status_d[STAT_VBLANK] = 1'b0;
						toggle_d              = 1'b0;
					end
					REG_OAM_DATA: begin
						rd_d = spr_rdata;
					end
					REG_DATA: begin
						// Reads are delayed through the buffer, except palette reads,
						// which return the fresh byte.
						rd_d   = (region == RGN_PAL) ? fetch : rbuf_q;
						rbuf_d = fetch;
						if (region == RGN_EXT) begin
							ext_used_d = 1'b1;
							ext_addr_d = a14;
						end
						cur_d = cur_step;
					end
					default: begin
					end
				endcase
			end
			ACT_WRITE: begin
				case (sel_s1)
					REG_CTRL: begin
						ctrl_d        = wdata_s1;
						temp_d[11:10] = wdata_s1[1:0];
					end
					REG_MASK: begin
						mask_d = wdata_s1;
					end
					REG_OAM_ADDR: begin
						sprptr_d = wdata_s1;
					end
					REG_OAM_DATA: begin
						sprptr_d = sprptr_q + 8'd1;
					end
					REG_SCROLL: begin
						// First write: coarse X. Second write: fine and coarse Y.
						if (!toggle_q) begin
							temp_d[4:0] = wdata_s1[7:3];
							toggle_d    = 1'b1;
						end else begin
							temp_d[14:12] = wdata_s1[2:0];
							temp_d[9:5]   = wdata_s1[7:3];
							toggle_d      = 1'b0;
						end
					end
					REG_ADDR: begin
						// High byte first, then the low byte, which also loads the
						// current address.
						if (!toggle_q) begin
							temp_d[15:8] = {2'b00, wdata_s1[5:0]};
							toggle_d     = 1'b1;
						end else begin
							temp_d[7:0] = wdata_s1;
							cur_d       = {temp_q[15:8], wdata_s1};
							toggle_d    = 1'b0;
						end
					end
					REG_DATA: begin
						if (region == RGN_EXT) begin
							ext_wr_d   = 1'b1;
							ext_addr_d = a14;
							ext_wd_d   = wdata_s1;
						end
						cur_d = cur_step;
					end
					default: begin
					end
				endcase
			end
			ACT_VBLANK: begin
				status_d[STAT_VBLANK] = 1'b1;
				nmi_d                 = ctrl_q[CTRL_NMI_EN];
			end
			ACT_PRERENDER: begin
				status_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= MIR_VERTICAL;
		end else if (cfg_we) begin
			mirror_q <= cfg_wdata;
		end
	end

	// Register state is updated only when the item completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			mask_q   <= '0;
			status_q <= '0;
			toggle_q <= 1'b0;
			temp_q   <= '0;
			cur_q    <= '0;
			rbuf_q   <= '0;
			sprptr_q <= '0;
		end else if (commit) begin
			ctrl_q   <= ctrl_d;
			mask_q   <= mask_d;
			status_q <= status_d;
			toggle_q <= toggle_d;
			temp_q   <= temp_d;
			cur_q    <= cur_d;
			rbuf_q   <= rbuf_d;
			sprptr_q <= sprptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			act_s1   <= cmd.action;
			sel_s1   <= cmd.reg_select;
			wdata_s1 <= cmd.write_data;
			xdata_s1 <= cmd.ext_read_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rd_q       <= rd_d;
			nmi_q      <= nmi_d;
			vaddr_q    <= cur_d;
			ext_wr_q   <= ext_wr_d;
			ext_addr_q <= ext_addr_d;
			ext_wd_q   <= ext_wd_d;
			ext_used_q <= ext_used_d;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.read_data      = rd_q;
	assign rsp.nmi_pulse      = nmi_q;
	assign rsp.video_address  = vaddr_q;
	assign rsp.ext_write      = ext_wr_q;
	assign rsp.ext_address    = ext_addr_q;
	assign rsp.ext_write_data = ext_wd_q;
	assign rsp.ext_read_used  = ext_used_q;

	// A result never reports an external write and an external read together.
	`VCRI_ASSERT_SAME(a_ext_exclusive, rsp.valid, !(rsp.ext_write && rsp.ext_read_used), "external read and write in one result")
	// The reported video address is the current address left by the item.
	`VCRI_ASSERT_NEXT(a_vaddr_tracks, commit, rsp.video_address == cur_q, "video address differs from current address")
	// A status read leaves the toggle and the vblank flag clear.
	`VCRI_ASSERT_NEXT(a_status_clears, commit && (act_s1 == ACT_READ) && (sel_s1 == REG_STATUS), !toggle_q && !status_q[STAT_VBLANK], "status read did not clear toggle or vblank")

endmodule
